// ===== sv/mau_pkg.sv =====
// mau_pkg: shared types and constants of the modular arithmetic unit
// item payload structs, action codes and the shared step unit's operand bundle
// no dependencies
`default_nettype none

package mau_pkg;

  localparam int unsigned RES_W = 31;
  localparam int unsigned RAW_W = 64;

  // modulus after reset
  localparam logic [RES_W-1:0] MOD_RESET = 31'd998244353;

  // action codes
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_NEG = 3'd4;
  localparam logic [2:0] ACT_INV = 3'd5;
  localparam logic [2:0] ACT_RAW = 3'd6;

  typedef struct packed {
    logic [2:0]              action;
    logic [RES_W-1:0]        operand_a;
    logic [RES_W-1:0]        operand_b;
    logic signed [RAW_W-1:0] raw_value;
  } in_t;

  typedef struct packed {
    logic [RES_W-1:0] result;
    logic             no_inverse;
  } out_t;

  // operands of the shared step unit
  typedef struct packed {
    logic             neg;
    logic [RES_W-1:0] x;
    logic [RES_W-1:0] y;
    logic             cin;
    logic [RES_W-1:0] k;
  } unit_in_t;

  typedef struct packed {
    logic [RES_W-1:0] value;
    logic             ge;
  } unit_out_t;

endpackage

`default_nettype wire

// ===== sv/mau_modstep.sv =====
// mau_modstep: shared add / compare-subtract unit of the modular arithmetic unit
// computes (x + y + cin) reduced once by k, or the negation k - x (0 stays 0)
// depends on mau_pkg
`default_nettype none

module mau_modstep (
  input  wire mau_pkg::unit_in_t op,
  output mau_pkg::unit_out_t     res
);

  logic [31:0] sum;
  logic [32:0] diff;
  logic        ge;
  logic [30:0] negv;

  // sum and trial subtract; sum stays below 2k so one subtract is enough
  assign sum  = {1'b0, op.x} + {1'b0, op.y} + {31'b0, op.cin};
  assign diff = {1'b0, sum} - {2'b0, op.k};
  assign ge   = ~diff[32];
  assign negv = op.k - op.x;

  // result select
  always_comb begin
    if (op.neg) begin
      res.value = (op.x == '0) ? '0 : negv;
      res.ge    = 1'b0;
    end else begin
      res.value = ge ? diff[30:0] : sum[30:0];
      res.ge    = ge;
    end
  end

endmodule

`default_nettype wire

// ===== sv/modular_arithmetic_unit_core.sv =====
// modular_arithmetic_unit_core: one item at a time through a bit-serial sequencer
// steps: both operands reduced bit-serially, then add, sub (negate b, then add), neg or a
// double-and-add mul; raw values reduced bit-serially, negated if negative; inverse/divide
// run extended Euclid with a restoring division of 31 quotient bits per round, divide adds
// a mul; in_ready only in idle, so a new item is taken only once the last result is loaded
// reset: synchronous rst clears control and loads modulus 998244353; depends on mau_pkg
`default_nettype none

module modular_arithmetic_unit_core (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire mau_pkg::in_t in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output mau_pkg::out_t    out_data,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire [30:0]       cfg_data
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RDA  = 5'd1;
  localparam logic [4:0] S_RDB  = 5'd2;
  localparam logic [4:0] S_ADD  = 5'd3;
  localparam logic [4:0] S_SUBN = 5'd4;
  localparam logic [4:0] S_NEG  = 5'd5;
  localparam logic [4:0] S_MDBL = 5'd6;
  localparam logic [4:0] S_MADD = 5'd7;
  localparam logic [4:0] S_ECHK = 5'd8;
  localparam logic [4:0] S_EDIV = 5'd9;
  localparam logic [4:0] S_EDBL = 5'd10;
  localparam logic [4:0] S_EADD = 5'd11;
  localparam logic [4:0] S_ENEG = 5'd12;
  localparam logic [4:0] S_EUPD = 5'd13;
  localparam logic [4:0] S_EEND = 5'd14;
  localparam logic [4:0] S_RAW  = 5'd15;
  localparam logic [4:0] S_RAWN = 5'd16;
  localparam logic [4:0] S_FIN  = 5'd17;

  logic [4:0]  state;
  logic [30:0] modulus;
  logic [2:0]  act;
  logic        raw_neg;
  logic [63:0] sh;
  logic [5:0]  cnt;
  logic [30:0] acc;
  logic        flag;
  logic [30:0] areg;
  logic [30:0] breg;
  logic [30:0] r0;
  logic [30:0] r1;
  logic [30:0] s0;
  logic [30:0] s1;
  logic [30:0] rem;
  logic [30:0] t;
  logic        qbit;

  logic               accept;
  logic               fin_load;
  logic [63:0]        raw_mag;
  mau_pkg::unit_in_t  u_in;
  mau_pkg::unit_out_t u_out;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign fin_load  = (state == S_FIN) && (!out_valid || out_ready);
  assign raw_mag   = in_data.raw_value[63] ? (~in_data.raw_value + 64'd1)
                                           : in_data.raw_value;

  // shared step unit
  mau_modstep u_step (
    .op  (u_in),
    .res (u_out)
  );

  // operand routing for the shared unit
  always_comb begin
    u_in     = '0;
    u_in.k   = modulus;
    unique case (state)
      S_RDA, S_RDB, S_RAW: begin
        u_in.x   = acc;
        u_in.y   = acc;
        u_in.cin = sh[cnt];
      end
      S_ADD: begin
        u_in.x = areg;
        u_in.y = breg;
      end
      S_SUBN: begin
        u_in.neg = 1'b1;
        u_in.x   = breg;
      end
      S_NEG: begin
        u_in.neg = 1'b1;
        u_in.x   = areg;
      end
      S_MDBL: begin
        u_in.x = acc;
        u_in.y = acc;
      end
      S_MADD: begin
        u_in.x = acc;
        u_in.y = areg;
      end
      S_EDIV: begin
        u_in.x   = rem;
        u_in.y   = rem;
        u_in.cin = r0[cnt[4:0]];
        u_in.k   = r1;
      end
      S_EDBL: begin
        u_in.x = t;
        u_in.y = t;
      end
      S_EADD: begin
        u_in.x = t;
        u_in.y = s1;
      end
      S_ENEG: begin
        u_in.neg = 1'b1;
        u_in.x   = t;
      end
      S_EUPD: begin
        u_in.x = s0;
        u_in.y = t;
      end
      S_RAWN: begin
        u_in.neg = 1'b1;
        u_in.x   = acc;
      end
      default: begin
        u_in.x = '0;
      end
    endcase
  end

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mau_pkg::MOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_data.result     <= acc;
      out_data.no_inverse <= flag;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act     <= in_data.action;
            raw_neg <= in_data.raw_value[63];
            acc     <= '0;
            flag    <= 1'b0;
            if (modulus[30:1] == '0 || in_data.action > mau_pkg::ACT_RAW) begin
              state <= S_FIN;
            end else if (in_data.action == mau_pkg::ACT_RAW) begin
              sh    <= raw_mag;
              cnt   <= 6'd63;
              state <= S_RAW;
            end else begin
              sh    <= {33'b0, in_data.operand_a};
              breg  <= in_data.operand_b;
              cnt   <= 6'd30;
              state <= S_RDA;
            end
          end
        end
        // operand a reduced one bit a cycle
        S_RDA: begin
          if (cnt == '0) begin
            areg  <= u_out.value;
            acc   <= '0;
            sh    <= {33'b0, breg};
            cnt   <= 6'd30;
            state <= S_RDB;
          end else begin
            acc <= u_out.value;
            cnt <= cnt - 6'd1;
          end
        end
        // operand b reduced, then dispatch on the action
        S_RDB: begin
          if (cnt == '0) begin
            breg <= u_out.value;
            unique case (act)
              mau_pkg::ACT_ADD: state <= S_ADD;
              mau_pkg::ACT_SUB: state <= S_SUBN;
              mau_pkg::ACT_NEG: state <= S_NEG;
              mau_pkg::ACT_MUL: begin
                acc   <= '0;
                sh    <= {33'b0, u_out.value};
                cnt   <= 6'd30;
                state <= S_MDBL;
              end
              mau_pkg::ACT_DIV: begin
                r0    <= modulus;
                r1    <= u_out.value;
                s0    <= '0;
                s1    <= 31'd1;
                state <= S_ECHK;
              end
              default: begin
                r0    <= modulus;
                r1    <= areg;
                s0    <= '0;
                s1    <= 31'd1;
                state <= S_ECHK;
              end
            endcase
          end else begin
            acc <= u_out.value;
            cnt <= cnt - 6'd1;
          end
        end
        S_ADD: begin
          acc   <= u_out.value;
          state <= S_FIN;
        end
        S_SUBN: begin
          breg  <= u_out.value;
          state <= S_ADD;
        end
        S_NEG: begin
          acc   <= u_out.value;
          state <= S_FIN;
        end
        // double and add multiply, multiplier bits msb first
        S_MDBL: begin
          acc <= u_out.value;
          if (sh[cnt]) begin
            state <= S_MADD;
          end else if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_MADD: begin
          acc <= u_out.value;
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt   <= cnt - 6'd1;
            state <= S_MDBL;
          end
        end
        // euclid round: r0 / r1 by restoring division, q * s1 kept modulo m
        S_ECHK: begin
          if (r1 == '0) begin
            state <= S_EEND;
          end else begin
            rem   <= '0;
            t     <= '0;
            cnt   <= 6'd30;
            state <= S_EDIV;
          end
        end
        S_EDIV: begin
          rem   <= u_out.value;
          qbit  <= u_out.ge;
          state <= S_EDBL;
        end
        S_EDBL: begin
          t <= u_out.value;
          if (qbit) begin
            state <= S_EADD;
          end else if (cnt == '0) begin
            state <= S_ENEG;
          end else begin
            cnt   <= cnt - 6'd1;
            state <= S_EDIV;
          end
        end
        S_EADD: begin
          t <= u_out.value;
          if (cnt == '0) begin
            state <= S_ENEG;
          end else begin
            cnt   <= cnt - 6'd1;
            state <= S_EDIV;
          end
        end
        S_ENEG: begin
          t     <= u_out.value;
          state <= S_EUPD;
        end
        // s_next = s0 - q * s1 modulo m, shift the remainder pair
        S_EUPD: begin
          r0    <= r1;
          r1    <= rem;
          s0    <= s1;
          s1    <= u_out.value;
          state <= S_ECHK;
        end
        S_EEND: begin
          if (r0 == 31'd1) begin
            if (act == mau_pkg::ACT_DIV) begin
              acc   <= '0;
              sh    <= {33'b0, s0};
              cnt   <= 6'd30;
              state <= S_MDBL;
            end else begin
              acc   <= s0;
              state <= S_FIN;
            end
          end else begin
            acc   <= '0;
            flag  <= 1'b1;
            state <= S_FIN;
          end
        end
        // signed raw value: magnitude reduced bit-serially, then negated if the value is negative
        S_RAW: begin
          acc <= u_out.value;
          if (cnt == '0) begin
            state <= raw_neg ? S_RAWN : S_FIN;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_RAWN: begin
          acc   <= u_out.value;
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_modular_arithmetic_unit_core.sv =====
`timescale 1ns / 1ps
// tb_modular_arithmetic_unit_core: self-checking bench for the modular arithmetic unit
// corner and random items over a series of moduli, each result checked against a local
// residue predictor; depends on mau_pkg and modular_arithmetic_unit_core

module tb_modular_arithmetic_unit_core;
  import mau_pkg::*;

  // slowest run: longest item plus long gap and stall per item, ~1180 items,
  // taken about five times over
  localparam longint unsigned CYCLE_LIMIT = 64'd30_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [RES_W-1:0] MOD_MAX = 31'h7FFFFFFF;
  localparam logic [2:0] ACT_UNDEF = 3'd7;
  localparam int PHASES = 9;

  typedef enum logic [1:0] {PLAN_ITEM, PLAN_MODULUS, PLAN_DRAIN} plan_kind_t;

  typedef struct packed {
    plan_kind_t       kind;
    in_t              item;
    logic [RES_W-1:0] modulus;
  } plan_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RES_W-1:0] cfg_data = '0;

  plan_entry_t item_plan[$];
  out_t pending_residues[$];
  logic [RES_W-1:0] model_modulus = MOD_RESET;
  longint unsigned cycle_count = 0;
  bit quiet_stretch = 1'b0;
  int fail_count = 0;
  int results_seen = 0;

  // driver and monitor scratch
  bit item_busy;
  bit cfg_busy;
  int send_gap = 0;
  int recv_stall = 0;
  plan_entry_t next_step;
  out_t want;

  modular_arithmetic_unit_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // extended euclid over signed 64-bit; returns 0 when v has no inverse mod m
  function automatic bit field_inverse(input longint unsigned v, input longint unsigned m,
                                       output longint unsigned inv);
    longint r0, r1, s0, s1, q, t;
    r0 = longint'(m);
    r1 = longint'(v);
    s0 = 0;
    s1 = 1;
    inv = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      t = r0 - q * r1;
      r0 = r1;
      r1 = t;
      t = s0 - q * s1;
      s0 = s1;
      s1 = t;
    end
    if (r0 != 1) return 1'b0;
    if (s0 < 0) s0 = s0 + longint'(m);
    inv = longint'(s0) % m;
    return 1'b1;
  endfunction

  // expected result of one item under modulus mod_v
  function automatic out_t residue_of(input in_t it, input logic [RES_W-1:0] mod_v);
    longint unsigned m, a, b, inv, rv, mag, r, res;
    out_t o;
    o = '0;
    res = 0;
    m = mod_v;
    if (m >= 2) begin
      a = it.operand_a % m;
      b = it.operand_b % m;
      rv = it.raw_value;
      case (it.action)
        ACT_ADD: res = (a + b) % m;
        ACT_SUB: res = (a + m - b) % m;
        ACT_MUL: res = (a * b) % m;
        ACT_DIV: begin
          if (field_inverse(b, m, inv)) res = (a * inv) % m;
          else o.no_inverse = 1'b1;
        end
        ACT_NEG: res = (a == 0) ? 0 : m - a;
        ACT_INV: begin
          if (field_inverse(a, m, inv)) res = inv;
          else o.no_inverse = 1'b1;
        end
        ACT_RAW: begin
          if (!rv[63]) begin
            res = rv % m;
          end else begin
            mag = ~rv + 64'd1;
            r = mag % m;
            res = (r == 0) ? 0 : m - r;
          end
        end
        default: res = 0;
      endcase
    end
    o.result = res[RES_W-1:0];
    return o;
  endfunction

  // idle length: mostly none or short, now and then long, none in quiet stretches
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_stretch) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned wanted);
    fail_count++;
    $display("mismatch at result %0d, %s: got %0d, expected %0d", results_seen, what, got,
             wanted);
  endtask

  // plan builders
  task automatic queue_item(input logic [2:0] act, input logic [RES_W-1:0] a,
                            input logic [RES_W-1:0] b, input longint raw);
    plan_entry_t e;
    e = '0;
    e.kind = PLAN_ITEM;
    e.item.action = act;
    e.item.operand_a = a;
    e.item.operand_b = b;
    e.item.raw_value = raw;
    item_plan.push_back(e);
  endtask

  task automatic queue_modulus(input logic [RES_W-1:0] m);
    plan_entry_t e;
    e = '0;
    e.kind = PLAN_MODULUS;
    e.modulus = m;
    item_plan.push_back(e);
  endtask

  task automatic queue_drain();
    plan_entry_t e;
    e = '0;
    e.kind = PLAN_DRAIN;
    item_plan.push_back(e);
  endtask

  // operand: mostly reduced, some full width, some at the edges
  function automatic logic [RES_W-1:0] pick_operand(input logic [RES_W-1:0] m);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6 && m != 0) return RES_W'($urandom_range(0, m - 1));
    if (roll < 8) return RES_W'($urandom());
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 31'd1;
      2: return m - 1;
      3: return m;
      default: return MOD_MAX;
    endcase
  endfunction

  // raw value: full random, near multiples of the modulus, or 64-bit edges
  function automatic longint pick_raw(input logic [RES_W-1:0] m);
    longint unsigned v, mm;
    mm = m;
    case ($urandom_range(0, 2))
      0: v = {$urandom(), $urandom()};
      1: begin
        v = mm * $urandom_range(0, 20) + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1) v = ~v + 64'd1;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 0;
          1: v = {64{1'b1}};
          2: v = 64'h8000_0000_0000_0000;
          3: v = 64'h7FFF_FFFF_FFFF_FFFF;
          default: v = 64'h8000_0000_0000_0001;
        endcase
      end
    endcase
    return longint'(v);
  endfunction

  task automatic queue_random(input logic [RES_W-1:0] m, input int count);
    int roll;
    logic [2:0] act;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 70);
      act = (roll == 70) ? ACT_UNDEF : 3'(roll / 10);
      queue_item(act, pick_operand(m), pick_operand(m), pick_raw(m));
      // one full pause mid-phase with nothing in flight
      if (i == count / 2) queue_drain();
    end
  endtask

  // driver: items and modulus writes from the plan
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      send_gap = 0;
      model_modulus = MOD_RESET;
    end else begin
      item_busy = in_valid;
      cfg_busy = cfg_valid;
      if (in_valid && in_ready) begin
        pending_residues.push_back(residue_of(in_data, model_modulus));
        item_busy = 1'b0;
        send_gap = pick_gap();
      end
      if (cfg_valid && cfg_ready) begin
        model_modulus = cfg_data;
        cfg_busy = 1'b0;
      end
      if (!item_busy && !cfg_busy && item_plan.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          next_step = item_plan[0];
          case (next_step.kind)
            PLAN_ITEM: begin
              in_data <= next_step.item;
              item_busy = 1'b1;
              next_step = item_plan.pop_front();
            end
            // modulus only changes with the unit idle
            PLAN_MODULUS: begin
              if (pending_residues.size() == 0) begin
                cfg_data <= next_step.modulus;
                cfg_busy = 1'b1;
                next_step = item_plan.pop_front();
              end
            end
            default: begin
              if (pending_residues.size() == 0) next_step = item_plan.pop_front();
            end
          endcase
        end
      end
      in_valid <= item_busy;
      cfg_valid <= cfg_busy;
    end
  end

  // monitor: check results in order, random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_residues.size() == 0) begin
          report_mismatch("result with nothing pending", out_data.result, 0);
        end else begin
          want = pending_residues.pop_front();
          if (out_data.result !== want.result)
            report_mismatch("result", out_data.result, want.result);
          if (out_data.no_inverse !== want.no_inverse)
            report_mismatch("no_inverse", out_data.no_inverse, want.no_inverse);
        end
      end
      if (recv_stall > 0) recv_stall--;
      else if ($urandom_range(0, 7) == 0) recv_stall = pick_gap();
      out_ready <= (recv_stall == 0);
    end
  end

  // cycle limit and quiet stretches without idling
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    quiet_stretch <= ((cycle_count / 25000) % 4) == 3;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [RES_W-1:0] phase_mod [PHASES];
    int phase_items [PHASES];
    logic [RES_W-1:0] m;

    phase_mod[0] = MOD_MAX;               phase_items[0] = 200;
    phase_mod[1] = 31'd2;                 phase_items[1] = 80;
    phase_mod[2] = 31'd1000000;           phase_items[2] = 150;
    phase_mod[3] = '0;                    phase_items[3] = 20;
    phase_mod[4] = 31'd1;                 phase_items[4] = 20;
    phase_mod[5] = 31'h40000000 | RES_W'($urandom()); phase_items[5] = 150;
    phase_mod[6] = 31'd65536;             phase_items[6] = 100;
    phase_mod[7] = 31'd3;                 phase_items[7] = 60;
    phase_mod[8] = 31'd1000000007;        phase_items[8] = 120;

    // corners at the reset modulus
    m = MOD_RESET;
    queue_item(ACT_ADD, m - 1, m - 1, 0);
    queue_item(ACT_ADD, 0, 0, -1);
    queue_item(ACT_SUB, 0, m - 1, 0);
    queue_item(ACT_SUB, 5, 5, 0);
    queue_item(ACT_MUL, m - 1, m - 1, 0);
    queue_item(ACT_MUL, MOD_MAX, MOD_MAX, 0);
    queue_item(ACT_DIV, 12345, 0, 0);
    queue_item(ACT_DIV, m - 1, m - 1, 0);
    queue_item(ACT_DIV, 0, 3, 0);
    // divisor that reduces to zero
    queue_item(ACT_DIV, MOD_MAX, m, 0);
    queue_item(ACT_NEG, 0, MOD_MAX, 0);
    queue_item(ACT_NEG, 1, 0, 0);
    queue_item(ACT_NEG, MOD_MAX, 0, 0);
    queue_item(ACT_INV, 0, 0, 0);
    queue_item(ACT_INV, 1, 0, 0);
    queue_item(ACT_INV, m - 1, 0, 0);
    queue_item(ACT_INV, m, 0, 0);
    queue_item(ACT_RAW, MOD_MAX, MOD_MAX, 0);
    queue_item(ACT_RAW, 0, 0, -1);
    queue_item(ACT_RAW, 0, 0, 64'sh8000_0000_0000_0000);
    queue_item(ACT_RAW, 0, 0, 64'sh7FFF_FFFF_FFFF_FFFF);
    queue_item(ACT_RAW, 0, 0, -longint'(m));
    queue_item(ACT_RAW, 0, 0, longint'(m));
    queue_item(ACT_UNDEF, MOD_MAX, MOD_MAX, -1);
    queue_random(MOD_RESET, 250);

    // each phase: idle write of a new modulus, then random items
    for (int p = 0; p < PHASES; p++) begin
      queue_drain();
      queue_modulus(phase_mod[p]);
      // operands sharing a factor with a composite modulus
      if (phase_mod[p] == 31'd1000000) begin
        queue_item(ACT_INV, 2, 0, 0);
        queue_item(ACT_DIV, 7, 5, 0);
      end
      queue_random(phase_mod[p], phase_items[p]);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (item_plan.size() != 0 || in_valid || cfg_valid || pending_residues.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mau_pkg.sv
sv/mau_modstep.sv
sv/modular_arithmetic_unit_core.sv
tb/tb_modular_arithmetic_unit_core.sv
